// ===== rtl/core/lru_page_replacement_defines.svh =====
// Assertion macros used by the LRU page replacement checker
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset
`define LRUPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lrupr same-cycle check failed");

// Next-cycle implication, sampled on clk, idle during reset
`define LRUPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrupr next-cycle check failed");

`endif

// ===== rtl/core/lrupr_pkg.sv =====
// Shared types and constants for the LRU page replacement block
package lrupr_pkg;

  localparam int CFG_W      = 4;
  localparam int PAGE_IN_W  = 16;
  localparam int FIDX_W     = 3;
  localparam int HIT_W      = 16;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
  localparam logic [HIT_W-1:0] HIT_MAX   = 16'hFFFF;

  // Control for the recency update
  typedef struct packed {
    logic en;       // apply the update this cycle
    logic age_all;  // fill of an empty frame: every other valid frame ages
  } age_ctrl_t;

endpackage

// ===== rtl/core/lrupr_age.sv =====
// Parallel recency-rank update applied once per reference
module lrupr_age #(
  parameter int FRAMES = 8,
  parameter int RW     = 3
) (
  input  lrupr_pkg::age_ctrl_t ctrl,
  input  logic [RW-1:0]        sel_f,
  input  logic [RW-1:0]        limit,
  input  logic [RW-1:0]        last_idx,
  input  logic [FRAMES-1:0]    valid,
  input  logic [RW-1:0]        rank [FRAMES],
  output logic [RW-1:0]        rank_next [FRAMES]
);
  import lrupr_pkg::*;

  localparam logic [RW-1:0] RMAX = RW'(FRAMES - 1);

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_next[i] = rank[i];
      if (ctrl.en && (RW'(i) <= last_idx)) begin
        if (RW'(i) == sel_f) begin
          rank_next[i] = '0;
        end else if (valid[i] && (ctrl.age_all || rank[i] < limit) && rank[i] != RMAX) begin
          rank_next[i] = rank[i] + 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lru_page_replacement.sv =====
// An accepted start enters SCAN, which walks the active frames (1..FRAMES); UPDATE then raises the done strobe.
// A hit ends the scan early.
// The block does not accept a new reference while busy with the current one.
// The scan makes one page compare per cycle through a single comparator.
// Reset (rst, synchronous): frames empty, ranks and hit count zero, frames_in_use back to 8.
// Frame page contents are not cleared; no clearing pass is needed.
module lru_page_replacement #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]     cfg_wr_data,
  input  logic                            start,
  input  logic [lrupr_pkg::PAGE_IN_W-1:0] page_number,
  output logic                            busy,
  output logic                            done,
  output logic                            hit,
  output logic [lrupr_pkg::FIDX_W-1:0]    frame_index,
  output logic                            evicted_valid,
  output logic [lrupr_pkg::PAGE_IN_W-1:0] evicted_page,
  output logic [lrupr_pkg::HIT_W-1:0]     hit_total
);
  import lrupr_pkg::*;

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [CFG_W:0] FRAMES_C = (CFG_W + 1)'(FRAMES);

  typedef enum logic [1:0] {IDLE, SCAN, UPDATE} state_t;

  state_t                 state;
  logic [CFG_W-1:0]       frames_in_use;
  logic [PAGE_BITS-1:0]   frame_page [FRAMES];
  logic [FRAMES-1:0]      frame_valid;
  logic [IW-1:0]          rank [FRAMES];
  logic [IW-1:0]          rank_next [FRAMES];
  logic [HIT_W-1:0]       hit_counter;

  logic [IW-1:0]          idx;
  logic [PAGE_BITS-1:0]   page_q;
  logic                   hit_q;
  logic [IW-1:0]          hit_f;
  logic                   empty_q;
  logic [IW-1:0]          empty_f;
  logic [IW-1:0]          best;
  logic [IW-1:0]          vic_f;
  logic [PAGE_BITS-1:0]   vic_page;

  logic [IW-1:0]          last_idx;
  logic [CFG_W-1:0]       cfg_m1;
  logic [PAGE_BITS-1:0]   cur_page;
  logic                   cur_valid;
  logic [IW-1:0]          cur_rank;
  logic                   match;
  logic [IW-1:0]          sel_f;
  logic                   evict;
  logic [HIT_W-1:0]       hit_counter_next;
  age_ctrl_t              age_ctrl;

  // Clamp the register to 1..FRAMES, held as the last frame index
  assign cfg_m1 = frames_in_use - 1'b1;
  always_comb begin
    if (frames_in_use == '0) begin
      last_idx = '0;
    end else if ({1'b0, frames_in_use} > FRAMES_C) begin
      last_idx = IW'(FRAMES - 1);
    end else begin
      last_idx = cfg_m1[IW-1:0];
    end
  end

  assign cur_page  = frame_page[idx];
  assign cur_valid = frame_valid[idx];
  assign cur_rank  = rank[idx];
  assign match     = cur_valid && (cur_page == page_q);

  assign sel_f = hit_q ? hit_f : (empty_q ? empty_f : vic_f);
  assign evict = !hit_q && !empty_q;
  assign hit_counter_next = (hit_q && hit_counter != HIT_MAX) ? hit_counter + 1'b1
                                                              : hit_counter;

  assign age_ctrl.en      = (state == UPDATE);
  assign age_ctrl.age_all = !hit_q && empty_q;

  // best holds the hit frame's rank on a hit, the victim's rank otherwise
  lrupr_age #(
    .FRAMES (FRAMES),
    .RW     (IW)
  ) u_age (
    .ctrl      (age_ctrl),
    .sel_f     (sel_f),
    .limit     (best),
    .last_idx  (last_idx),
    .valid     (frame_valid),
    .rank      (rank),
    .rank_next (rank_next)
  );

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (state == UPDATE && !hit_q) begin
      frame_page[sel_f] <= page_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      frames_in_use <= CFG_RESET;
      frame_valid   <= '0;
      hit_counter   <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        rank[i] <= '0;
      end
      idx           <= '0;
      page_q        <= '0;
      hit_q         <= 1'b0;
      hit_f         <= '0;
      empty_q       <= 1'b0;
      empty_f       <= '0;
      best          <= '0;
      vic_f         <= '0;
      vic_page      <= '0;
      done          <= 1'b0;
      hit           <= 1'b0;
      frame_index   <= '0;
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
      hit_total     <= '0;
    end else begin
      done <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        rank[i] <= rank_next[i];
      end
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      case (state)
        IDLE: begin
          if (start) begin
            page_q  <= PAGE_BITS'(page_number);
            idx     <= '0;
            hit_q   <= 1'b0;
            empty_q <= 1'b0;
            best    <= '0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          if (match) begin
            hit_q <= 1'b1;
            hit_f <= idx;
            best  <= cur_rank;
            state <= UPDATE;
          end else begin
            if (!cur_valid && !empty_q) begin
              empty_q <= 1'b1;
              empty_f <= idx;
            end
            // first frame seeds the victim; later ones replace it only when strictly older
            if (idx == '0 || cur_rank > best) begin
              best     <= cur_rank;
              vic_f    <= idx;
              vic_page <= cur_page;
            end
            if (idx == last_idx) begin
              state <= UPDATE;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        UPDATE: begin
          if (!hit_q) begin
            frame_valid[sel_f] <= 1'b1;
          end
          hit_counter   <= hit_counter_next;
          done          <= 1'b1;
          hit           <= hit_q;
          frame_index   <= FIDX_W'(sel_f);
          evicted_valid <= evict;
          evicted_page  <= evict ? PAGE_IN_W'(vic_page) : '0;
          hit_total     <= hit_counter_next;
          state         <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/lrupr_checker.sv =====
// Port-level checks for the LRU page replacement block, bound to the top level
`include "lru_page_replacement_defines.svh"

module lrupr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic                            hit,
  input logic                            evicted_valid,
  input logic [lrupr_pkg::PAGE_IN_W-1:0] evicted_page,
  input logic [lrupr_pkg::HIT_W-1:0]     hit_total
);
  import lrupr_pkg::*;

  // an accepted reference keeps the block busy in the next cycle
  `LRUPR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // the result beat appears only once the block has gone idle
  `LRUPR_ASSERT_NOW(a_done_idle, done, !busy)
  // a hit never evicts, and a result without an eviction reports a zero page
  `LRUPR_ASSERT_NOW(a_hit_no_evict, done && hit, !evicted_valid)
  `LRUPR_ASSERT_NOW(a_no_evict_zero, done && !evicted_valid, evicted_page == '0)
  // a hit beat always carries a non-zero running count
  `LRUPR_ASSERT_NOW(a_hit_count, done && hit, hit_total != '0)

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .hit_total     (hit_total)
);

// ===== sim/tb_lru_page_replacement.sv =====
// Self-checking testbench for the LRU page replacement block: directed table, random phases
`timescale 1ns / 1ps

module tb_lru_page_replacement;
  import lrupr_pkg::*;

  localparam int FRAMES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEMS_PER_PHASE = 133;
  localparam int NUM_PHASES = 12;
  localparam int NUM_STEPS = 24;

  typedef struct packed {
    logic                 hit;
    logic [FIDX_W-1:0]    frame;
    logic                 evicted;
    logic [PAGE_IN_W-1:0] victim_page;
    logic [HIT_W-1:0]     hits;
  } lookup_t;

  typedef enum bit {ROW_REF, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [PAGE_IN_W-1:0] value;
    logic                 typed;
    lookup_t              want;
  } step_row_t;

  // Typed results only where they follow directly from reset or extremes
  localparam step_row_t STEPS [NUM_STEPS] = '{
    '{ROW_REF, 16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd0}},
    '{ROW_REF, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd0}},
    '{ROW_REF, 16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0002, 1'b1, '{1'b0, 3'd2, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0003, 1'b1, '{1'b0, 3'd3, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0004, 1'b1, '{1'b0, 3'd4, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0005, 1'b1, '{1'b0, 3'd5, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0006, 1'b1, '{1'b0, 3'd6, 1'b0, 16'h0000, 16'd1}},
    '{ROW_REF, 16'h0007, 1'b1, '{1'b0, 3'd7, 1'b0, 16'h0000, 16'd1}},
    // all frames full: oldest is frame 1
    '{ROW_REF, 16'h8000, 1'b1, '{1'b0, 3'd1, 1'b1, 16'hFFFF, 16'd1}},
    '{ROW_REF, 16'h0000, 1'b0, '0},
    // zero limit acts as one frame
    '{ROW_CFG, 16'h0000, 1'b0, '0},
    '{ROW_REF, 16'h0007, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h0000, 16'd2}},
    '{ROW_REF, 16'h0007, 1'b0, '0},
    // oversize limit acts as eight; page 7 now sits in two frames
    '{ROW_CFG, 16'h000F, 1'b0, '0},
    '{ROW_REF, 16'h0007, 1'b0, '0},
    '{ROW_REF, 16'h0005, 1'b0, '0},
    '{ROW_CFG, 16'h0003, 1'b0, '0},
    '{ROW_REF, 16'h0005, 1'b0, '0},
    '{ROW_REF, 16'h1234, 1'b0, '0},
    // raising the limit again gives colliding ranks
    '{ROW_CFG, 16'h0008, 1'b0, '0},
    '{ROW_REF, 16'hABCD, 1'b0, '0},
    '{ROW_REF, 16'h5555, 1'b0, '0},
    '{ROW_REF, 16'hAAAA, 1'b0, '0}
  };

  localparam logic [CFG_W-1:0] PHASE_LIMIT [NUM_PHASES] = '{
    4'd1, 4'd8, 4'd2, 4'd15, 4'd5, 4'd0, 4'd7, 4'd12, 4'd3, 4'd8, 4'd4, 4'd6
  };

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_W-1:0]     cfg_wr_data;
  logic                 start;
  logic [PAGE_IN_W-1:0] page_number;
  logic                 busy;
  logic                 done;
  logic                 hit;
  logic [FIDX_W-1:0]    frame_index;
  logic                 evicted_valid;
  logic [PAGE_IN_W-1:0] evicted_page;
  logic [HIT_W-1:0]     hit_total;

  lru_page_replacement DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .start         (start),
    .page_number   (page_number),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .hit_total     (hit_total)
  );

  // predictor state
  logic [PAGE_IN_W-1:0] res_page [FRAMES];
  bit                   res_valid [FRAMES];
  int unsigned          age_rank [FRAMES];
  logic [HIT_W-1:0]     hit_cnt;
  logic [CFG_W-1:0]     limit_reg;

  lookup_t              lookup_q [$];
  bit                   typed_row;
  lookup_t              typed_want;
  logic [PAGE_IN_W-1:0] base_pages [24];
  logic [PAGE_IN_W-1:0] pool [$];

  int  errors;
  int  refs_sent;
  int  results_seen;
  int  limit_writes;
  int  stall_cycles;
  bit  saw_hit_max;

  wire accept = start && !busy && !rst;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int active_frames();
    if (limit_reg < 1) return 1;
    if (limit_reg > FRAMES) return FRAMES;
    return int'(limit_reg);
  endfunction

  // frame f becomes most recent; frames younger than lim, or every valid frame with age_all, age by one
  function automatic void promote(int f, int n, int unsigned lim, bit age_all);
    for (int i = 0; i < n; i++) begin
      if (i != f && res_valid[i] && (age_all || age_rank[i] < lim) &&
          age_rank[i] < FRAMES - 1)
        age_rank[i]++;
    end
    age_rank[f] = 0;
  endfunction

  function automatic lookup_t lookup_page(logic [PAGE_IN_W-1:0] page);
    lookup_t     r;
    int          n;
    int          f;
    bit          found;
    int unsigned best;
    n = active_frames();
    r = '0;
    f = 0;
    found = 1'b0;
    for (int i = 0; i < n && !found; i++) begin
      if (res_valid[i] && res_page[i] == page) begin
        found = 1'b1;
        f = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      promote(f, n, age_rank[f], 1'b0);
      if (hit_cnt != HIT_MAX) hit_cnt++;
    end else begin
      for (int i = 0; i < n && !found; i++) begin
        if (!res_valid[i]) begin
          found = 1'b1;
          f = i;
        end
      end
      if (found) begin
        res_valid[f] = 1'b1;
        res_page[f] = page;
        promote(f, n, 0, 1'b1);
      end else begin
        // lowest index wins among equal oldest ranks
        best = 0;
        f = 0;
        for (int i = 0; i < n; i++) begin
          if (age_rank[i] > best) begin
            best = age_rank[i];
            f = i;
          end
        end
        r.evicted = 1'b1;
        r.victim_page = res_page[f];
        res_page[f] = page;
        promote(f, n, age_rank[f], 1'b0);
      end
    end
    r.frame = FIDX_W'(f);
    r.hits = hit_cnt;
    return r;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t ns: %s expected %0h got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    lookup_t got;
    lookup_t want;
    if (!rst) begin
      // retire the older beat first: a result and a new reference can share an edge
      if (done) begin
        got = '{hit, frame_index, evicted_valid, evicted_page, hit_total};
        results_seen++;
        if (got.hits == HIT_MAX) saw_hit_max = 1'b1;
        if (lookup_q.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t ns: result expected none got %0h", $time, got);
        end else begin
          want = lookup_q.pop_front();
          check_field("hit", want.hit, got.hit);
          check_field("frame_index", want.frame, got.frame);
          check_field("evicted_valid", want.evicted, got.evicted);
          check_field("evicted_page", want.victim_page, got.victim_page);
          check_field("hit_total", want.hits, got.hits);
        end
      end
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (accept) begin
        want = lookup_page(page_number);
        lookup_q.push_back(typed_row ? typed_want : want);
        refs_sent++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || accept || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no beat for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, lookup_q.size());
        $display("tb_lru_page_replacement: FAIL");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic drive_ref(logic [PAGE_IN_W-1:0] page, bit typed, lookup_t want, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    page_number <= page;
    typed_row <= typed;
    typed_want <= want;
    do @(posedge clk); while (!accept);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    typed_row <= 1'b0;
    @(negedge clk);
    while (lookup_q.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    limit_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [PAGE_IN_W-1:0] pick_page();
    int r;
    r = $urandom_range(99);
    if (r < 85) return pool[$urandom_range(pool.size() - 1)];
    if (r < 95) return base_pages[$urandom_range(23)];
    return PAGE_IN_W'($urandom);
  endfunction

  initial begin
    int idle_pct;
    int n;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    start = 1'b0;
    page_number = '0;
    typed_row = 1'b0;
    typed_want = '0;
    errors = 0;
    refs_sent = 0;
    results_seen = 0;
    limit_writes = 0;
    stall_cycles = 0;
    saw_hit_max = 1'b0;
    for (int i = 0; i < FRAMES; i++) begin
      res_page[i] = '0;
      res_valid[i] = 1'b0;
      age_rank[i] = 0;
    end
    hit_cnt = '0;
    limit_reg = CFG_RESET;
    base_pages[0] = 16'h0000;
    base_pages[1] = 16'hFFFF;
    for (int i = 2; i < 24; i++) base_pages[i] = PAGE_IN_W'($urandom);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (STEPS[i]) begin
      if (STEPS[i].kind == ROW_CFG) begin
        wait_idle();
        write_limit(STEPS[i].value[CFG_W-1:0]);
      end else begin
        drive_ref(STEPS[i].value, STEPS[i].typed, STEPS[i].want, 0);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_limit(PHASE_LIMIT[ph]);
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 72;
        default: idle_pct = 30;
      endcase
      n = (PHASE_LIMIT[ph] < 1) ? 1 : (PHASE_LIMIT[ph] > FRAMES) ? FRAMES : PHASE_LIMIT[ph];
      // working set of the frame count plus up to four pages, so hits and evictions mix
      pool.delete();
      repeat (n + $urandom_range(0, 4)) pool.push_back(base_pages[$urandom_range(23)]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 4) wait_idle();
        drive_ref(pick_page(), 1'b0, '0, idle_pct);
      end
    end

    wait_idle();
    write_limit(4'd8);
    pool.delete();
    repeat (10) pool.push_back(base_pages[$urandom_range(23)]);
    repeat (40) drive_ref(pick_page(), 1'b0, '0, 30);

    wait_idle();
    repeat (16) @(posedge clk);

    $display("run covered %0d references, %0d results, %0d limit writes",
             refs_sent, results_seen, limit_writes);
    $display("hit count saturation reached: %0s, mismatches: %0d",
             saw_hit_max ? "yes" : "no", errors);
    if (errors == 0)
      $display("tb_lru_page_replacement: PASS");
    else
      $display("tb_lru_page_replacement: FAIL");
    $finish;
  end

endmodule
